/* src/aes256_gcm_engine_core_defines.svh */
// Assertion macros used by the engine core RTL file.
`ifndef AES256_GCM_ENGINE_CORE_DEFINES_SVH
`define AES256_GCM_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTH
`define AGCM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("agcm assertion failed");
`define AGCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("agcm assertion failed");
`else
`define AGCM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define AGCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/agcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package agcm_pkg;

    localparam int MAX_PAYLOAD  = 250;
    localparam int GCM_OVERHEAD = 28;
    localparam int AES_ROUNDS   = 14;
    localparam int RK_DEPTH     = AES_ROUNDS + 1;
    localparam int RK_AW        = $clog2(RK_DEPTH);
    localparam int GH_DIGIT     = 4;
    localparam int GH_STEPS     = 128 / GH_DIGIT;
    localparam int GH_CW        = $clog2(GH_STEPS);
    localparam logic [63:0] GF_REDUCE = 64'hE100_0000_0000_0000;

    // operation codes
    localparam logic [1:0] OP_START_ENC = 2'd0;
    localparam logic [1:0] OP_START_DEC = 2'd1;
    localparam logic [1:0] OP_DATA      = 2'd2;
    localparam logic [1:0] OP_FINISH    = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_TAG    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_KEY   = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;
    localparam logic [1:0] ST_MISMATCH = 2'd3;

    // configuration register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] REG_KEY0      = 3'd0;
    localparam logic [CFG_IW-1:0] REG_KEY1      = 3'd1;
    localparam logic [CFG_IW-1:0] REG_KEY2      = 3'd2;
    localparam logic [CFG_IW-1:0] REG_KEY3      = 3'd3;
    localparam logic [CFG_IW-1:0] REG_KEY_VALID = 3'd4;

    typedef struct packed {
        logic busy;
        logic done;
    } gh_stat_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    // multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

`default_nettype wire

/* src/agcm_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface agcm_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [agcm_pkg::CFG_IW-1:0] index;
    logic [63:0]                  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface agcm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] iv_head;
    logic [63:0] iv_tail;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
    modport source (output valid, operation, iv_head, iv_tail, data_high, data_low,
                    byte_count, input ready);
    modport sink   (input valid, operation, iv_head, iv_tail, data_high, data_low,
                    byte_count, output ready);
endinterface

interface agcm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [63:0] out_high;
    logic [63:0] out_low;
    logic [4:0]  out_bytes;
    logic [1:0]  status;
    modport source (output valid, kind, out_high, out_low, out_bytes, status, input ready);
    modport sink   (input valid, kind, out_high, out_low, out_bytes, status, output ready);
endinterface

`default_nettype wire

/* src/aes256_gcm_engine_core.sv */
// AES-256-GCM engine, 96-bit IV, no associated data, 16-byte tag.
// Channels: cfg writes the key words (index 0..3) and key_valid (index 4);
// cfg.ready is always high, and writes are expected only while idle.
// din carries one word per item: start encrypt/decrypt (with IV), data
// block (up to 16 bytes), or finish. dout returns at most one word per item:
// a data block, the tag (encrypt finish) or a status (decrypt or failed finish).
// A start expands the key one word per cycle and then runs two AES
// encryptions, H and E(J0), and gives no result. A data block runs
// one AES pass (one round per cycle on the shared round unit) and then
// a GHASH multiply (4 bits per cycle). A finish runs one GHASH multiply.
// Failed or empty blocks and failed finishes skip AES and GHASH. The
// engine takes one item at a time; din.ready is high only while the
// sequencer is idle.
// A result sits in the dout register until taken; a further item is still
// accepted meanwhile, and its result waits in the sequencer until the
// output register frees, so a stalled receiver holds the engine then.
// Reset clears the key, the message state and the output; round keys hold
// garbage until the first start.
`timescale 1ns / 1ps
`default_nettype none
`include "aes256_gcm_engine_core_defines.svh"

module aes256_gcm_engine_core (
    input  logic              clk,
    input  logic              rst_n,
    agcm_cfg_if.sink          cfg,
    agcm_in_if.sink           din,
    agcm_out_if.source        dout
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_KEXP  = 5'b00010,
        ST_AES   = 5'b00100,
        ST_GHASH = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    typedef enum logic [1:0] {
        JOB_H,   // hash subkey E(0)
        JOB_T,   // tag mask E(J0)
        JOB_D,   // data block
        JOB_F    // finish
    } job_t;

    // configuration
    logic [63:0] key_reg [4];
    logic        key_valid_reg;

    // sequencer
    state_t      state_reg, state_next;
    job_t        job_reg, job_next;
    logic [5:0]  kcnt_reg, kcnt_next;
    logic [agcm_pkg::RK_AW-1:0] rnd_reg, rnd_next;
    logic [7:0]  rc_reg;
    logic [31:0] win_reg [8];

    // message state
    logic [127:0] hsub_reg;
    logic [127:0] tmask_reg;
    logic [127:0] acc_reg;
    logic [31:0]  iv_head_reg;
    logic [63:0]  iv_tail_reg;
    logic [31:0]  ctr_reg;
    logic [15:0]  msg_reg;
    logic         dec_reg;
    logic [1:0]   failed_reg;

    // working block
    logic [127:0] dat_reg;
    logic [127:0] mask_reg;
    logic [4:0]   n_reg;
    logic [127:0] aes_blk_reg;
    logic [127:0] aes_s_reg;

    // pending result
    logic [1:0]   res_kind_reg;
    logic [127:0] res_data_reg;
    logic [4:0]   res_bytes_reg;
    logic [1:0]   res_status_reg;

    // output register
    logic         out_valid_reg;
    logic [1:0]   out_kind_reg;
    logic [127:0] out_data_reg;
    logic [4:0]   out_bytes_reg;
    logic [1:0]   out_status_reg;

    // round key memory
    logic [127:0] rk_mem [agcm_pkg::RK_DEPTH];
    logic [127:0] rk_q_reg;
    logic         rk_we;
    logic [agcm_pkg::RK_AW-1:0] rk_waddr;
    logic [127:0] rk_wdata;

    // combinational helpers
    logic         in_acc;
    logic [4:0]   n_sat;
    logic [127:0] in_mask;
    logic [17:0]  len_sum;
    logic [17:0]  len_limit;
    logic [1:0]   failed_chk;
    logic [31:0]  kx_t;
    logic [31:0]  kx_sub;
    logic [31:0]  kx_new;
    logic [127:0] round_out;
    logic [127:0] aes_next;
    logic         aes_last;
    logic [127:0] cipher;
    logic [127:0] tag_calc;
    logic         gh_start;
    logic [127:0] gh_x;
    agcm_pkg::gh_stat_t gh_stat;
    logic [127:0] gh_z;
    logic         out_load;

    assign cfg.ready = 1'b1;
    assign din.ready = (state_reg == ST_IDLE);
    assign in_acc    = din.valid && din.ready;

    assign dout.valid     = out_valid_reg;
    assign dout.kind      = out_kind_reg;
    assign dout.out_high  = out_data_reg[127:64];
    assign dout.out_low   = out_data_reg[63:0];
    assign dout.out_bytes = out_bytes_reg;
    assign dout.status    = out_status_reg;

    // Clamp the byte count, build the leading-byte mask and check the length limit.
    always_comb
    begin
        n_sat = (din.byte_count > 5'd16) ? 5'd16 : din.byte_count;
        for (int j = 0; j < 16; j++)
        begin
            in_mask[127 - 8 * j -: 8] = (5'(j) < n_sat) ? 8'hff : 8'h00;
        end
        len_sum   = {2'b00, msg_reg} + {13'd0, n_sat} + 18'(agcm_pkg::GCM_OVERHEAD);
        len_limit = dec_reg ? 18'd65535 : 18'(agcm_pkg::MAX_PAYLOAD);
        failed_chk = failed_reg;
        if (failed_reg == agcm_pkg::ST_OK && n_sat != 5'd0 && len_sum > len_limit)
        begin
            failed_chk = agcm_pkg::ST_TOO_LONG;
        end
    end

    // Key schedule step: one 32-bit word per cycle over an 8-word window.
    always_comb
    begin
        kx_t = win_reg[7];
        case (kcnt_reg[2:0])
            3'd0:
            begin
                kx_sub = {agcm_pkg::sbox(kx_t[23:16]) ^ rc_reg, agcm_pkg::sbox(kx_t[15:8]),
                          agcm_pkg::sbox(kx_t[7:0]), agcm_pkg::sbox(kx_t[31:24])};
            end
            3'd4:
            begin
                kx_sub = {agcm_pkg::sbox(kx_t[31:24]), agcm_pkg::sbox(kx_t[23:16]),
                          agcm_pkg::sbox(kx_t[15:8]), agcm_pkg::sbox(kx_t[7:0])};
            end
            default:
            begin
                kx_sub = kx_t;
            end
        endcase
        kx_new = win_reg[0] ^ kx_sub;
    end

    // Round key writes: the raw key first, then each completed group of four expanded words.
    always_comb
    begin
        rk_we    = 1'b0;
        rk_waddr = '0;
        rk_wdata = {win_reg[5], win_reg[6], win_reg[7], kx_new};
        if (state_reg == ST_KEXP)
        begin
            if (kcnt_reg < 6'd2)
            begin
                rk_we    = 1'b1;
                rk_waddr = agcm_pkg::RK_AW'(kcnt_reg);
                rk_wdata = kcnt_reg[0] ? {key_reg[2], key_reg[3]} : {key_reg[0], key_reg[1]};
            end
            else if (kcnt_reg[1:0] == 2'd3)
            begin
                rk_we    = 1'b1;
                rk_waddr = kcnt_reg[5:2];
            end
        end
    end

    agcm_aes_round u_round (
        .state_in  (aes_s_reg),
        .last      (aes_last),
        .round_key (rk_q_reg),
        .state_out (round_out)
    );

    assign aes_last = (rnd_reg == agcm_pkg::RK_AW'(agcm_pkg::AES_ROUNDS));
    assign aes_next = (rnd_reg == '0) ? (aes_blk_reg ^ rk_q_reg) : round_out;
    assign cipher   = (dat_reg ^ aes_next) & mask_reg;
    assign tag_calc = gh_z ^ tmask_reg;

    agcm_ghash u_ghash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gh_start),
        .x_in  (gh_x),
        .h_in  (hsub_reg),
        .stat  (gh_stat),
        .z_out (gh_z)
    );

    // Sequencer next state and GHASH launch.
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        kcnt_next  = kcnt_reg;
        rnd_next   = '0;
        gh_start   = 1'b0;
        gh_x       = acc_reg ^ {109'd0, msg_reg, 3'd0};
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (din.operation)
                        agcm_pkg::OP_START_ENC, agcm_pkg::OP_START_DEC:
                        begin
                            state_next = ST_KEXP;
                            kcnt_next  = '0;
                        end
                        agcm_pkg::OP_DATA:
                        begin
                            if (failed_chk != agcm_pkg::ST_OK || n_sat == 5'd0)
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                state_next = ST_AES;
                                job_next   = JOB_D;
                            end
                        end
                        default:
                        begin
                            if (failed_reg != agcm_pkg::ST_OK)
                            begin
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                gh_start   = 1'b1;
                                state_next = ST_GHASH;
                                job_next   = JOB_F;
                            end
                        end
                    endcase
                end
            end
            ST_KEXP:
            begin
                if (kcnt_reg == 6'd1)
                begin
                    kcnt_next = 6'd8;
                end
                else if (kcnt_reg == 6'd59)
                begin
                    state_next = ST_AES;
                    job_next   = JOB_H;
                end
                else
                begin
                    kcnt_next = kcnt_reg + 6'd1;
                end
            end
            ST_AES:
            begin
                if (!aes_last)
                begin
                    rnd_next = rnd_reg + 1'b1;
                end
                else
                begin
                    case (job_reg)
                        JOB_H:
                        begin
                            job_next = JOB_T;
                        end
                        JOB_T:
                        begin
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            gh_start   = 1'b1;
                            gh_x       = acc_reg ^ (dec_reg ? dat_reg : cipher);
                            state_next = ST_GHASH;
                        end
                    endcase
                end
            end
            ST_GHASH:
            begin
                if (gh_stat.done)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and message state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= JOB_H;
            kcnt_reg      <= '0;
            rnd_reg       <= '0;
            rc_reg        <= 8'h01;
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            key_valid_reg <= 1'b0;
            hsub_reg      <= '0;
            tmask_reg     <= '0;
            acc_reg       <= '0;
            iv_head_reg   <= '0;
            iv_tail_reg   <= '0;
            ctr_reg       <= 32'd2;
            msg_reg       <= '0;
            dec_reg       <= 1'b0;
            failed_reg    <= agcm_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            kcnt_reg  <= kcnt_next;
            rnd_reg   <= rnd_next;

            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    agcm_pkg::REG_KEY0:      key_reg[0]    <= cfg.data;
                    agcm_pkg::REG_KEY1:      key_reg[1]    <= cfg.data;
                    agcm_pkg::REG_KEY2:      key_reg[2]    <= cfg.data;
                    agcm_pkg::REG_KEY3:      key_reg[3]    <= cfg.data;
                    agcm_pkg::REG_KEY_VALID: key_valid_reg <= cfg.data[0];
                    default:                 ;
                endcase
            end

            // start: latch direction and IV, reset the message
            if (in_acc && (din.operation == agcm_pkg::OP_START_ENC ||
                           din.operation == agcm_pkg::OP_START_DEC))
            begin
                dec_reg     <= (din.operation == agcm_pkg::OP_START_DEC);
                iv_head_reg <= din.iv_head;
                iv_tail_reg <= din.iv_tail;
                acc_reg     <= '0;
                ctr_reg     <= 32'd2;
                msg_reg     <= '0;
                failed_reg  <= key_valid_reg ? agcm_pkg::ST_OK : agcm_pkg::ST_NO_KEY;
                rc_reg      <= 8'h01;
            end
            else if (in_acc && din.operation == agcm_pkg::OP_DATA)
            begin
                failed_reg <= failed_chk;
            end

            // advance rcon once per eight expanded words
            if (state_reg == ST_KEXP && kcnt_reg >= 6'd8 && kcnt_reg[2:0] == 3'd0)
            begin
                rc_reg <= agcm_pkg::xtime(rc_reg);
            end

            if (state_reg == ST_AES && aes_last && job_reg == JOB_H)
            begin
                hsub_reg <= aes_next;
            end
            if (state_reg == ST_AES && aes_last && job_reg == JOB_T)
            begin
                tmask_reg <= aes_next;
            end

            // fold the block into the hash and advance the counter
            if (state_reg == ST_GHASH && gh_stat.done && job_reg == JOB_D)
            begin
                acc_reg <= gh_z;
                ctr_reg <= ctr_reg + 32'd1;
                msg_reg <= msg_reg + {11'd0, n_reg};
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (din.operation == agcm_pkg::OP_START_ENC ||
                din.operation == agcm_pkg::OP_START_DEC)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    win_reg[2 * i]     <= key_reg[i][63:32];
                    win_reg[2 * i + 1] <= key_reg[i][31:0];
                end
                aes_blk_reg <= '0;
            end
            else if (din.operation == agcm_pkg::OP_DATA)
            begin
                dat_reg     <= {din.data_high, din.data_low} & in_mask;
                mask_reg    <= in_mask;
                n_reg       <= n_sat;
                aes_blk_reg <= {iv_head_reg, iv_tail_reg, ctr_reg};
            end
            else
            begin
                dat_reg <= {din.data_high, din.data_low};
            end

            // failed or empty blocks and failed finishes answer at once
            res_kind_reg   <= (din.operation == agcm_pkg::OP_FINISH) ?
                              agcm_pkg::KIND_STATUS : agcm_pkg::KIND_DATA;
            res_data_reg   <= '0;
            res_bytes_reg  <= '0;
            res_status_reg <= (din.operation == agcm_pkg::OP_FINISH) ? failed_reg : failed_chk;
        end

        if (state_reg == ST_KEXP && kcnt_reg >= 6'd8)
        begin
            for (int i = 0; i < 7; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[7] <= kx_new;
        end

        if (state_reg == ST_AES)
        begin
            aes_s_reg <= aes_next;
            if (aes_last && job_reg == JOB_H)
            begin
                aes_blk_reg <= {iv_head_reg, iv_tail_reg, 32'd1};
            end
            if (aes_last && job_reg == JOB_D)
            begin
                res_kind_reg   <= agcm_pkg::KIND_DATA;
                res_data_reg   <= cipher;
                res_bytes_reg  <= n_reg;
                res_status_reg <= agcm_pkg::ST_OK;
            end
        end

        if (state_reg == ST_GHASH && gh_stat.done && job_reg == JOB_F)
        begin
            if (dec_reg)
            begin
                res_kind_reg   <= agcm_pkg::KIND_STATUS;
                res_data_reg   <= '0;
                res_bytes_reg  <= '0;
                res_status_reg <= (tag_calc == dat_reg) ? agcm_pkg::ST_OK :
                                                          agcm_pkg::ST_MISMATCH;
            end
            else
            begin
                res_kind_reg   <= agcm_pkg::KIND_TAG;
                res_data_reg   <= tag_calc;
                res_bytes_reg  <= 5'd16;
                res_status_reg <= agcm_pkg::ST_OK;
            end
        end

        if (out_load)
        begin
            out_kind_reg   <= res_kind_reg;
            out_data_reg   <= res_data_reg;
            out_bytes_reg  <= res_bytes_reg;
            out_status_reg <= res_status_reg;
        end
    end

    // Round key memory: one write port, registered read of the next round.
    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[rk_waddr] <= rk_wdata;
        end
        rk_q_reg <= rk_mem[rnd_next];
    end

    `AGCM_ASSERT_IMPL(a_gh_start_idle, clk, rst_n, gh_start, !gh_stat.busy)
    `AGCM_ASSERT_IMPL(a_gh_done_owned, clk, rst_n, gh_stat.done, state_reg == ST_GHASH)
    `AGCM_ASSERT_IMPL(a_rnd_range, clk, rst_n, state_reg == ST_AES,
                      rnd_reg <= agcm_pkg::RK_AW'(agcm_pkg::AES_ROUNDS))
    `AGCM_ASSERT_NEXT(a_kexp_to_aes, clk, rst_n,
                      state_reg == ST_KEXP && kcnt_reg == 6'd59,
                      state_reg == ST_AES && rnd_reg == '0 && job_reg == JOB_H)

endmodule

`default_nettype wire

/* src/agcm_aes_round.sv */
`timescale 1ns / 1ps
`default_nettype none

// One AES encryption round: SubBytes, ShiftRows, MixColumns (skipped on the
// last round), AddRoundKey.
module agcm_aes_round (
    input  logic [127:0] state_in,
    input  logic         last,
    input  logic [127:0] round_key,
    output logic [127:0] state_out
);

    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] m [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i] = state_in[127 - 8 * i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                t[4 * c + i] = agcm_pkg::sbox(s[4 * ((c + i) & 3) + i]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            m[4 * c]     = agcm_pkg::xtime(t[4 * c]) ^ agcm_pkg::xtime(t[4 * c + 1])
                           ^ t[4 * c + 1] ^ t[4 * c + 2] ^ t[4 * c + 3];
            m[4 * c + 1] = t[4 * c] ^ agcm_pkg::xtime(t[4 * c + 1])
                           ^ agcm_pkg::xtime(t[4 * c + 2]) ^ t[4 * c + 2] ^ t[4 * c + 3];
            m[4 * c + 2] = t[4 * c] ^ t[4 * c + 1] ^ agcm_pkg::xtime(t[4 * c + 2])
                           ^ agcm_pkg::xtime(t[4 * c + 3]) ^ t[4 * c + 3];
            m[4 * c + 3] = agcm_pkg::xtime(t[4 * c]) ^ t[4 * c] ^ t[4 * c + 1]
                           ^ t[4 * c + 2] ^ agcm_pkg::xtime(t[4 * c + 3]);
        end
        for (int i = 0; i < 16; i++)
        begin
            state_out[127 - 8 * i -: 8] = (last ? t[i] : m[i]) ^ round_key[127 - 8 * i -: 8];
        end
    end

endmodule

`default_nettype wire

/* src/agcm_ghash.sv */
`timescale 1ns / 1ps
`default_nettype none

// GF(2^128) multiplier, GCM bit order, GH_DIGIT bits of x per cycle.
module agcm_ghash (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [127:0]       x_in,
    input  logic [127:0]       h_in,
    output agcm_pkg::gh_stat_t stat,
    output logic [127:0]       z_out
);

    logic [127:0]               z_reg, z_next;
    logic [127:0]               v_reg, v_next;
    logic [127:0]               x_reg;
    logic [agcm_pkg::GH_CW-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    always_comb
    begin
        z_next = z_reg;
        v_next = v_reg;
        for (int k = 0; k < agcm_pkg::GH_DIGIT; k++)
        begin
            if (x_reg[127 - k])
            begin
                z_next = z_next ^ v_next;
            end
            v_next = {1'b0, v_next[127:1]}
                     ^ (v_next[0] ? {agcm_pkg::GF_REDUCE, 64'd0} : 128'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == agcm_pkg::GH_CW'(agcm_pkg::GH_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            z_reg <= '0;
            v_reg <= h_in;
            x_reg <= x_in;
        end
        else if (busy_reg)
        begin
            z_reg <= z_next;
            v_reg <= v_next;
            x_reg <= {x_reg[127 - agcm_pkg::GH_DIGIT:0], {agcm_pkg::GH_DIGIT{1'b0}}};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign z_out     = z_reg;

endmodule

`default_nettype wire
